// ===== hw/rtl/mcsr_pkg.sv =====
// Package for the multi-channel motor speed ramp unit.
// Holds action, mode, status and state codes and the speed helper functions.
// No dependencies.
package mcsr_pkg;

  localparam int CFG_W    = 9;
  localparam int CH_W     = 4;
  localparam int NUM_W    = 40;
  localparam int CIDX_W   = 2;
  localparam int SPD_MAX  = 63;
  localparam int SPD_MIN  = 6;

  typedef enum logic [2:0] {
    A_SET     = 3'd0,
    A_STANDBY = 3'd1,
    A_BRAKE   = 3'd2,
    A_CHANGE  = 3'd3,
    A_RAMP    = 3'd4,
    A_TICK    = 3'd5,
    A_GET     = 3'd6
  } action_t;

  localparam logic [1:0] M_STANDBY = 2'd0;
  localparam logic [1:0] M_FORWARD = 2'd1;
  localparam logic [1:0] M_REVERSE = 2'd2;
  localparam logic [1:0] M_BRAKE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CH  = 2'd1;

  localparam logic [CIDX_W-1:0] R_PRESENT = 2'd0;
  localparam logic [CIDX_W-1:0] R_REVERSE = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_BAD,
    S_SCAN,
    S_TREAD,
    S_TMUL,
    S_TNUM,
    S_TABS,
    S_TDIV,
    S_TWB
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] spd;
  } drive_t;

  function automatic logic [5:0] clamp_mag(input logic [7:0] s);
    logic [5:0] m;
    if (s == 8'd0) m = 6'd0;
    else if (s < 8'(SPD_MIN)) m = 6'(SPD_MIN);
    else if (s > 8'(SPD_MAX)) m = 6'(SPD_MAX);
    else m = s[5:0];
    return m;
  endfunction

  function automatic logic is_big(input logic signed [6:0] v);
    return (v >= 7'sd6) || (v <= -7'sd6);
  endfunction

  function automatic logic signed [6:0] sat_add(input logic signed [6:0] s,
                                                input logic signed [7:0] d);
    logic signed [8:0] t;
    logic signed [6:0] r;
    t = 9'(s) + 9'(d);
    if (t > 9'sd63) r = 7'sd63;
    else if (t < -9'sd63) r = -7'sd63;
    else r = t[6:0];
    return r;
  endfunction

  function automatic drive_t drive_of(input logic signed [6:0] v, input logic rb);
    drive_t d;
    logic [6:0] a;
    a = v[6] ? 7'(-v) : 7'(v);
    if (is_big(v)) begin
      d.mode = (v[6] ^ rb) ? M_REVERSE : M_FORWARD;
      d.spd  = a[5:0];
    end else begin
      d.mode = M_STANDBY;
      d.spd  = 6'd0;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/mcsr_if.sv =====
// Channel interfaces of the motor speed ramp unit: command, result, config.
// Depends on mcsr_pkg for field widths.
interface mcsr_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 action;
  logic [mcsr_pkg::CH_W-1:0]  channel;
  logic                       direction;
  logic [7:0]                 speed;
  logic signed [7:0]          change;
  logic [30:0]                time_amount;
  modport source (output valid, action, channel, direction, speed, change, time_amount,
                  input ready);
  modport sink (input valid, action, channel, direction, speed, change, time_amount,
                output ready);
endinterface

interface mcsr_out_if;
  logic                       valid;
  logic                       ready;
  logic [mcsr_pkg::CH_W-1:0]  out_channel;
  logic                       write_valid;
  logic [1:0]                 drive_mode;
  logic [5:0]                 drive_speed;
  logic [1:0]                 status;
  logic signed [6:0]          speed_now;
  logic                       last;
  modport source (output valid, out_channel, write_valid, drive_mode, drive_speed, status,
                  speed_now, last, input ready);
  modport sink (input valid, out_channel, write_valid, drive_mode, drive_speed, status,
                speed_now, last, output ready);
endinterface

interface mcsr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mcsr_pkg::CIDX_W-1:0]  index;
  logic [mcsr_pkg::CFG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/multi_channel_motor_speed_ramp_unit.sv =====
// Top level of the multi-channel motor speed ramp unit.
// Depends on mcsr_pkg and the interfaces in mcsr_if.sv.
//
//  port  dir   carries
//  cmd   sink  action, channel, direction, speed, change, time_amount
//  res   src   out_channel, write_valid, drive_mode, drive_speed, status, speed_now, last
//  cfg   sink  index, data (present_mask, reverse_mask)
//
// A single-channel action is accepted, reads the channel entry, then updates it.
// A tick scans one channel per cycle and stops at each ramping channel: it reads the
// entry, multiplies, adds the remainder, takes the magnitude, divides in the bit-serial
// restoring divider (one quotient bit per cycle) and writes back; a ramp that ends skips the divide.
// Entries never written read as zero; no clearing pass.
// Results stall the sequencer while the output register is full and not taken.
module multi_channel_motor_speed_ramp_unit #(
  parameter int NUM_CHANNELS = 9,
  parameter int TIME_BITS    = 32
) (
  input logic           clk,
  input logic           rst,
  mcsr_in_if.sink       cmd,
  mcsr_out_if.source    res,
  mcsr_cfg_if.sink      cfg
);

  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int REM_W = TIME_BITS + 1;
  localparam int MW    = 14 + REM_W + TIME_BITS;
  localparam int NW    = mcsr_pkg::NUM_W;
  localparam int CW    = $clog2(NW);
  localparam logic [15:0] CH_MASK = 16'((32'd1 << NUM_CHANNELS) - 1);

  mcsr_pkg::state_t state, state_next;

  logic [mcsr_pkg::CFG_W-1:0] present, reverse;
  logic [15:0] pres16, rev16;
  logic [NUM_CHANNELS-1:0] active, pend;

  logic [MW-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic [MW-1:0] rdata;
  logic rvld;

  logic [AW-1:0] cur;
  logic [2:0] act_r;
  logic [mcsr_pkg::CH_W-1:0] chn_r;
  logic rev_r;
  logic [7:0] spd_r;
  logic signed [7:0] chg_r;
  logic [30:0] t_r;

  logic [MW-1:0] ent_w, ent;
  logic signed [6:0] e_spd, e_tgt;
  logic signed [REM_W-1:0] e_rem;
  logic [TIME_BITS-1:0] e_tl;
  logic signed [6:0] k_spd, k_tgt;
  logic signed [REM_W-1:0] k_rem;
  logic [TIME_BITS-1:0] k_tl;

  logic fin;
  logic signed [NW-1:0] prod, num;
  logic neg;
  logic [NW-1:0] quo;
  logic [TIME_BITS:0] prem;
  logic [CW-1:0] cnt;

  logic out_v, out_free, ld, we, act_set, act_clr;
  logic [MW-1:0] wdata;
  logic [mcsr_pkg::CH_W-1:0] o_ch;
  logic o_wv, o_last;
  logic [1:0] o_mode, o_st;
  logic [5:0] o_spd;
  logic signed [6:0] o_now;

  logic cmd_ok, rb, tl_gt;
  logic [5:0] m_in;
  logic signed [6:0] v_req, v_new, q8s;
  logic [6:0] qsat;
  mcsr_pkg::drive_t dv;
  logic [TIME_BITS:0] ptry;
  logic [REM_W-1:0] rmag;

  assign pres16 = 16'(present) & CH_MASK;
  assign rev16  = 16'(reverse) & CH_MASK;
  assign cmd_ok = pres16[cmd.channel];
  assign rb     = rev16[4'(cur)];

  assign ent_w = rvld ? rdata : '0;
  assign {e_spd, e_tgt, e_rem, e_tl} = ent_w;
  assign {k_spd, k_tgt, k_rem, k_tl} = ent;

  assign cmd.ready = (state == mcsr_pkg::S_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign out_free  = !out_v || res.ready;
  assign tl_gt     = 32'(e_tl) > 32'(t_r);
  assign m_in      = mcsr_pkg::clamp_mag(spd_r);
  assign v_req     = rev_r ? -7'(signed'({1'b0, m_in})) : 7'(signed'({1'b0, m_in}));
  assign qsat      = (|quo[NW-1:7]) ? 7'd127 : quo[6:0];
  assign q8s       = 7'(0);
  assign ptry      = {prem[TIME_BITS-1:0], quo[NW-1]};
  assign rmag      = REM_W'(prem[TIME_BITS-1:0]);

  always_comb begin
    state_next = state;
    unique case (state)
      mcsr_pkg::S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.action > mcsr_pkg::A_GET) state_next = mcsr_pkg::S_IDLE;
          else if (cmd.action == mcsr_pkg::A_TICK) state_next = mcsr_pkg::S_SCAN;
          else if (!cmd_ok) state_next = mcsr_pkg::S_BAD;
          else state_next = mcsr_pkg::S_READ;
        end
      end
      mcsr_pkg::S_READ:  state_next = mcsr_pkg::S_EXEC;
      mcsr_pkg::S_EXEC:  if (out_free) state_next = mcsr_pkg::S_IDLE;
      mcsr_pkg::S_BAD:   if (out_free) state_next = mcsr_pkg::S_IDLE;
      mcsr_pkg::S_SCAN: begin
        if (pend == '0) state_next = mcsr_pkg::S_IDLE;
        else if (pend[cur]) state_next = mcsr_pkg::S_TREAD;
      end
      mcsr_pkg::S_TREAD: state_next = mcsr_pkg::S_TMUL;
      mcsr_pkg::S_TMUL:  state_next = tl_gt ? mcsr_pkg::S_TNUM : mcsr_pkg::S_TWB;
      mcsr_pkg::S_TNUM:  state_next = mcsr_pkg::S_TABS;
      mcsr_pkg::S_TABS:  state_next = mcsr_pkg::S_TDIV;
      mcsr_pkg::S_TDIV:  if (cnt == CW'(NW - 1)) state_next = mcsr_pkg::S_TWB;
      mcsr_pkg::S_TWB:   if (out_free) state_next = mcsr_pkg::S_SCAN;
      default:           state_next = mcsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ld = 1'b0;
    we = 1'b0;
    act_set = 1'b0;
    act_clr = 1'b0;
    wdata = ent_w;
    o_ch = 4'(cur);
    o_wv = 1'b0;
    o_mode = mcsr_pkg::M_STANDBY;
    o_spd = 6'd0;
    o_st = mcsr_pkg::ST_OK;
    o_now = e_spd;
    o_last = 1'b1;
    v_new = e_spd;
    dv = mcsr_pkg::drive_of(e_spd, rb);
    unique case (state)
      mcsr_pkg::S_BAD: begin
        ld = out_free;
        o_ch = chn_r;
        o_st = mcsr_pkg::ST_BAD_CH;
        o_now = 7'sd0;
      end
      mcsr_pkg::S_EXEC: begin
        ld = out_free;
        case (act_r)
          mcsr_pkg::A_SET, mcsr_pkg::A_CHANGE: begin
            v_new = (act_r == mcsr_pkg::A_SET) ? v_req : mcsr_pkg::sat_add(e_spd, chg_r);
            dv = mcsr_pkg::drive_of(v_new, rb);
            we = out_free;
            act_clr = out_free;
            wdata = {v_new, e_tgt, e_rem, e_tl};
            o_wv = 1'b1;
            o_mode = dv.mode;
            o_spd = dv.spd;
            o_now = v_new;
          end
          mcsr_pkg::A_STANDBY, mcsr_pkg::A_BRAKE: begin
            v_new = mcsr_pkg::is_big(e_spd) ? 7'sd0 : e_spd;
            we = out_free;
            act_clr = out_free;
            wdata = {v_new, e_tgt, e_rem, e_tl};
            o_wv = 1'b1;
            o_mode = (act_r == mcsr_pkg::A_BRAKE) ? mcsr_pkg::M_BRAKE : mcsr_pkg::M_STANDBY;
            o_now = v_new;
          end
          mcsr_pkg::A_RAMP: begin
            we = out_free;
            act_set = out_free;
            wdata = {e_spd, v_req, REM_W'(0), TIME_BITS'(t_r)};
          end
          default: begin
          end
        endcase
      end
      mcsr_pkg::S_TWB: begin
        ld = out_free;
        we = out_free;
        o_last = ((pend & ~(NUM_CHANNELS'(1) << cur)) == '0);
        o_wv = 1'b1;
        if (fin) begin
          v_new = k_tgt;
          act_clr = out_free;
          wdata = {v_new, k_tgt, k_rem, TIME_BITS'(0)};
        end else begin
          v_new = mcsr_pkg::sat_add(k_spd, neg ? -8'(signed'({1'b0, qsat}))
                                               : 8'(signed'({1'b0, qsat})));
          wdata = {v_new, k_tgt, neg ? -rmag : rmag, k_tl - TIME_BITS'(t_r)};
        end
        dv = mcsr_pkg::drive_of(v_new, rb);
        o_mode = dv.mode;
        o_spd = dv.spd;
        o_now = v_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[cur];
    rvld  <= vld[cur];
    if (we) mem[cur] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mcsr_pkg::S_IDLE;
      present <= mcsr_pkg::CFG_W'(9'h1FF & CH_MASK[8:0]);
      reverse <= '0;
      active  <= '0;
      vld     <= '0;
      out_v   <= 1'b0;
      pend    <= '0;
      cur     <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        if (cfg.index == mcsr_pkg::R_PRESENT) present <= cfg.data & CH_MASK[8:0];
        else if (cfg.index == mcsr_pkg::R_REVERSE) reverse <= cfg.data & CH_MASK[8:0];
      end
      if (we) vld[cur] <= 1'b1;
      if (act_set) active[cur] <= 1'b1;
      if (act_clr) active[cur] <= 1'b0;
      if (ld) out_v <= 1'b1;
      else if (res.ready) out_v <= 1'b0;
      if (state == mcsr_pkg::S_IDLE && cmd.valid) begin
        pend <= active & pres16[NUM_CHANNELS-1:0];
        if (cmd.action == mcsr_pkg::A_TICK) cur <= '0;
        else cur <= AW'(cmd.channel);
      end
      if (state == mcsr_pkg::S_SCAN && pend != '0 && !pend[cur]) cur <= cur + 1'b1;
      if (state == mcsr_pkg::S_TWB && out_free) begin
        pend <= pend & ~(NUM_CHANNELS'(1) << cur);
        cur  <= cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcsr_pkg::S_IDLE && cmd.valid) begin
      act_r <= cmd.action;
      chn_r <= cmd.channel;
      rev_r <= cmd.direction;
      spd_r <= cmd.speed;
      chg_r <= cmd.change;
      t_r   <= cmd.time_amount;
    end
    if (state == mcsr_pkg::S_TMUL) begin
      ent  <= ent_w;
      fin  <= !tl_gt;
      prod <= NW'(8'(e_tgt) - 8'(e_spd)) * NW'(signed'({1'b0, t_r}));
    end
    if (state == mcsr_pkg::S_TNUM) num <= prod + NW'(k_rem);
    if (state == mcsr_pkg::S_TABS) begin
      neg  <= num[NW-1];
      quo  <= num[NW-1] ? NW'(-num) : NW'(num);
      prem <= '0;
      cnt  <= '0;
    end
    if (state == mcsr_pkg::S_TDIV) begin
      cnt <= cnt + 1'b1;
      if (ptry >= {1'b0, k_tl}) begin
        prem <= ptry - {1'b0, k_tl};
        quo  <= {quo[NW-2:0], 1'b1};
      end else begin
        prem <= ptry;
        quo  <= {quo[NW-2:0], 1'b0};
      end
    end
    if (ld) begin
      res.out_channel <= o_ch;
      res.write_valid <= o_wv;
      res.drive_mode  <= o_mode;
      res.drive_speed <= o_spd;
      res.status      <= o_st;
      res.speed_now   <= o_now + q8s;
      res.last        <= o_last;
    end
  end

  assign res.valid = out_v;

endmodule
